/* hw/rtl/cmf_pkg.sv */
`default_nettype none
package cmf_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int VALUE_WIDTH = 32;
    localparam int Q_W         = 17;
    localparam int CNT_W       = 7;
    localparam int REG_IDX_W   = 2;

    localparam logic [Q_W-1:0] Q_ONE = 17'h10000;

    // Item kinds carried on tuser
    localparam logic CMD_MAP   = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_VALUE_MIN   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_VALUE_MAX   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd2;

    typedef struct packed {
        logic [Q_W-1:0] pos;
        logic [Q_W-1:0] red;
        logic [Q_W-1:0] green;
        logic [Q_W-1:0] blue;
    } cmf_entry_t;

    typedef struct packed {
        logic                   cmd;
        logic [VALUE_WIDTH-1:0] value;
        logic [IDX_W-1:0]       idx;
        cmf_entry_t             entry;
    } cmf_item_t;

    // Saturate a Q1.16 field to one
    function automatic logic [Q_W-1:0] qsat(input logic [Q_W-1:0] x);
        qsat = (x > Q_ONE) ? Q_ONE : x;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/cmf_div.sv */
`default_nettype none
module cmf_div
    import cmf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [VALUE_WIDTH-1:0] num,
    input  wire logic [VALUE_WIDTH-1:0] den,
    output logic                        done,
    output logic [Q_W-1:0]              quot
);

    logic                   busy_reg, busy_next;
    logic [4:0]             step_reg, step_next;
    logic [VALUE_WIDTH-1:0] den_reg, den_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]         quot_reg, quot_next;
    logic                   done_reg, done_next;
    logic [VALUE_WIDTH:0]   rem_shift;
    logic                   take;

    assign rem_shift = {rem_reg, 1'b0};
    assign take      = (rem_shift >= {1'b0, den_reg});

    // One quotient bit per cycle, integer bit first (num never exceeds den)
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 5'd0;
            den_next  = den;
            if (num >= den)
            begin
                rem_next  = num - den;
                quot_next = {{(Q_W-1){1'b0}}, 1'b1};
            end
            else
            begin
                rem_next  = num;
                quot_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_next = VALUE_WIDTH'(rem_shift - {1'b0, den_reg});
            end
            else
            begin
                rem_next = rem_shift[VALUE_WIDTH-1:0];
            end
            quot_next = {quot_reg[Q_W-2:0], take};
            step_next = step_reg + 5'd1;
            if (step_reg == 5'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire

/* hw/rtl/cmf_front.sv */
`default_nettype none
module cmf_front
    import cmf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire cmf_item_t in_item,
    output logic           q_valid,
    input  wire logic      q_pop,
    output cmf_item_t      q_item
);

    cmf_item_t  slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    cmf_item_t  clean;
    logic       push;

    // Saturate the Q1.16 fields of a beat on its way in
    always_comb
    begin
        clean             = in_item;
        clean.entry.pos   = qsat(in_item.entry.pos);
        clean.entry.red   = qsat(in_item.entry.red);
        clean.entry.green = qsat(in_item.entry.green);
        clean.entry.blue  = qsat(in_item.entry.blue);
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Hold queued beats
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= clean;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/cmf_back.sv */
`default_nettype none
module cmf_back
    import cmf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [VALUE_WIDTH-1:0] value_min,
    input  wire logic [VALUE_WIDTH-1:0] value_max,
    input  wire logic [CNT_W-1:0]       entry_count,
    input  wire logic                   q_valid,
    output logic                        q_pop,
    input  wire cmf_item_t              q_item,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [24:0]                 out_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EMPTY = 4'd1;
    localparam logic [3:0] S_DIV1  = 4'd2;
    localparam logic [3:0] S_SRCH  = 4'd3;
    localparam logic [3:0] S_SEG   = 4'd4;
    localparam logic [3:0] S_DIV2  = 4'd5;
    localparam logic [3:0] S_MIX   = 4'd6;
    localparam logic [3:0] S_BYTE  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    cmf_entry_t mem [TABLE_DEPTH];
    cmf_entry_t rd_data;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;

    logic [3:0]       state_reg, state_next;
    logic [Q_W-1:0]   t_reg, t_next;
    logic [Q_W-1:0]   f_reg, f_next;
    logic [IDX_W-1:0] j_reg, j_next;
    cmf_entry_t       prev_reg, prev_next;
    cmf_entry_t       cur_reg, cur_next;
    logic [1:0]       ch_reg, ch_next;
    logic [32:0]      mix_reg, mix_next;
    logic [7:0]       red_reg, red_next, green_reg, green_next, blue_reg, blue_next;
    logic             out_valid_reg, out_valid_next;
    logic [24:0]      out_data_reg, out_data_next;

    logic                   div_start, div_done;
    logic [VALUE_WIDTH-1:0] div_num, div_den;
    logic [Q_W-1:0]         div_quot;

    logic [CNT_W-1:0]       n_eff;
    logic [IDX_W-1:0]       last;
    logic [VALUE_WIDTH-1:0] v_clamp;
    logic [Q_W-1:0]         u_clamp;
    logic [Q_W-1:0]         c_lo, c_hi;
    logic [33:0]            p_lo, p_hi;
    logic [40:0]            scaled;
    logic [24:0]            e_r, e_g, e_b;

    cmf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Clamp the breakpoint count, the incoming value and the normalized value to the segment
    always_comb
    begin
        if (entry_count < CNT_W'(2))
        begin
            n_eff = CNT_W'(2);
        end
        else if (entry_count > CNT_W'(TABLE_DEPTH))
        begin
            n_eff = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = entry_count;
        end
        last = IDX_W'(n_eff - CNT_W'(1));
        if (q_item.value < value_min)
        begin
            v_clamp = value_min;
        end
        else if (q_item.value > value_max)
        begin
            v_clamp = value_max;
        end
        else
        begin
            v_clamp = q_item.value;
        end
        if (t_reg < prev_reg.pos)
        begin
            u_clamp = prev_reg.pos;
        end
        else if (t_reg > cur_reg.pos)
        begin
            u_clamp = cur_reg.pos;
        end
        else
        begin
            u_clamp = t_reg;
        end
    end

    // Channel select and products for the blend, and scaling of results to bytes
    always_comb
    begin
        case (ch_reg)
            2'd0:
            begin
                c_lo = prev_reg.red;
                c_hi = cur_reg.red;
            end
            2'd1:
            begin
                c_lo = prev_reg.green;
                c_hi = cur_reg.green;
            end
            default:
            begin
                c_lo = prev_reg.blue;
                c_hi = cur_reg.blue;
            end
        endcase
        p_lo   = (Q_ONE - f_reg) * c_lo;
        p_hi   = f_reg * c_hi;
        scaled = {mix_reg, 8'd0} - {8'd0, mix_reg};
        e_r    = {rd_data.red, 8'd0} - {8'd0, rd_data.red};
        e_g    = {rd_data.green, 8'd0} - {8'd0, rd_data.green};
        e_b    = {rd_data.blue, 8'd0} - {8'd0, rd_data.blue};
    end

    // Sequencer: one queued item at a time
    always_comb
    begin
        state_next     = state_reg;
        t_next         = t_reg;
        f_next         = f_reg;
        j_next         = j_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        ch_next        = ch_reg;
        mix_next       = mix_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        rd_addr        = last;
        div_start      = 1'b0;
        div_num        = VALUE_WIDTH'(v_clamp - value_min);
        div_den        = VALUE_WIDTH'(value_max - value_min);
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.cmd == CMD_WRITE)
                    begin
                        mem_we = 1'b1;
                    end
                    else if (value_max <= value_min)
                    begin
                        state_next = S_EMPTY;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV1;
                    end
                end
            end
            S_EMPTY:
            begin
                red_next   = e_r[23:16];
                green_next = e_g[23:16];
                blue_next  = e_b[23:16];
                state_next = S_OUT;
            end
            S_DIV1:
            begin
                rd_addr = '0;
                if (div_done)
                begin
                    t_next     = div_quot;
                    j_next     = '0;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                rd_addr = IDX_W'(j_reg + IDX_W'(1));
                if (j_reg == '0)
                begin
                    prev_next = rd_data;
                    j_next    = IDX_W'(1);
                end
                else if (rd_data.pos >= t_reg || j_reg == last)
                begin
                    cur_next   = rd_data;
                    state_next = S_SEG;
                end
                else
                begin
                    prev_next = rd_data;
                    j_next    = IDX_W'(j_reg + IDX_W'(1));
                end
            end
            S_SEG:
            begin
                div_num = VALUE_WIDTH'(u_clamp - prev_reg.pos);
                div_den = VALUE_WIDTH'(cur_reg.pos - prev_reg.pos);
                ch_next = 2'd0;
                if (cur_reg.pos <= prev_reg.pos)
                begin
                    f_next     = Q_ONE;
                    state_next = S_MIX;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    f_next     = div_quot;
                    state_next = S_MIX;
                end
            end
            S_MIX:
            begin
                mix_next   = 33'(p_lo + p_hi);
                state_next = S_BYTE;
            end
            S_BYTE:
            begin
                case (ch_reg)
                    2'd0:    red_next   = scaled[39:32];
                    2'd1:    green_next = scaled[39:32];
                    default: blue_next  = scaled[39:32];
                endcase
                if (ch_reg == 2'd2)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = S_MIX;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = {1'b1, blue_reg, green_reg, red_reg};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        f_reg        <= f_next;
        j_reg        <= j_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        ch_reg       <= ch_next;
        mix_reg      <= mix_next;
        red_reg      <= red_next;
        green_reg    <= green_next;
        blue_reg     <= blue_next;
        out_data_reg <= out_data_next;
    end

    // Breakpoint and colour table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[q_item.idx] <= q_item.entry;
        end
        rd_data <= mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

/* hw/rtl/colormap_interpolate.sv */
// Piecewise-linear colormap lookup.
// Input stream: s_tuser selects the kind of beat (0 map a value, 1 write a table entry).
// A write beat stores a breakpoint position and RGB weights (Q1.16, saturated to one)
// and gives no output. A map beat gives one output beat with the interpolated RGB
// bytes and alpha set.
// Configuration: cfg_index 0 value_min, 1 value_max, 2 entry_count; always ready.
// The user must write it only while the block is idle; the block does not enforce it.
// A two-beat queue decouples input acceptance from the sequencer, which runs one
// item at a time. A write is stored in the table as it leaves the queue. A map
// leaves the queue, then passes through range normalization (one quotient bit per
// cycle), a walk of the table to its segment through its single read port, the
// segment fraction (skipped on a flat segment), blending of one channel at a time
// (a multiply pair, then scaling to a byte) and the load of the output register.
// An empty range skips the divisions and the walk and outputs the colour of the
// last breakpoint.
// Reset empties the queue and the output register and loads the range to the full
// 32-bit span with two breakpoints; table contents stay undefined until written.
// When m_tready is low the finished result holds in the output register; the
// sequencer waits on the next result while the queue keeps taking beats until full.
`default_nettype none
module colormap_interpolate
    import cmf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // value[31:0], entry_index[37:32], entry_position[54:38], entry_red[71:55],
    // entry_green[88:72], entry_blue[105:89], zero pad [111:106]
    input  wire logic [111:0]         s_tdata,
    // cmd
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // red[7:0], green[15:8], blue[23:16], alpha[24], zero pad [31:25]
    output logic [31:0]               m_tdata,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    logic [VALUE_WIDTH-1:0] value_min_reg, value_max_reg;
    logic [CNT_W-1:0]       entry_count_reg;
    cmf_item_t              in_item, q_item;
    logic                   q_valid, q_pop;
    logic [24:0]            out_data;

    // Unpack the input beat
    always_comb
    begin
        in_item.cmd         = s_tuser;
        in_item.value       = s_tdata[31:0];
        in_item.idx         = s_tdata[37:32];
        in_item.entry.pos   = s_tdata[54:38];
        in_item.entry.red   = s_tdata[71:55];
        in_item.entry.green = s_tdata[88:72];
        in_item.entry.blue  = s_tdata[105:89];
    end

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_min_reg   <= '0;
            value_max_reg   <= '1;
            entry_count_reg <= CNT_W'(2);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_VALUE_MIN:   value_min_reg   <= cfg_data;
                REG_VALUE_MAX:   value_max_reg   <= cfg_data;
                REG_ENTRY_COUNT: entry_count_reg <= cfg_data[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    cmf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    cmf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_min   (value_min_reg),
        .value_max   (value_max_reg),
        .entry_count (entry_count_reg),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (out_data)
    );

    assign m_tdata = {7'd0, out_data};

endmodule
`default_nettype wire
